// ===== rtl/core/lzgm_pkg.sv =====
// shared types and constants for the greedy lz77 match compressor
// no dependencies; used by lzgm_ctrl, lzgm_dp and the top level

package lzgm_pkg;

   localparam int WINDOW_DEF     = 32768;
   localparam int LOOKAHEAD_DEF  = 258;
   localparam int RING_DEPTH_DEF = 65536;
   localparam int SHORTEST_MATCH = 3;

   localparam int BYTE_W = 8;
   localparam int DIST_W = 16;
   localparam int LEN_W  = 9;
   localparam int RSP_W  = 40;   // 34 payload bits padded to whole bytes

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic CSR_MAX_DISTANCE = 1'b0;
   localparam logic CSR_MAX_LENGTH   = 1'b1;

   typedef struct packed {
      logic ready;       // idle, taking a request word
      logic setup;       // latch search bound, start at distance 1
      logic cand_init;   // start comparing one candidate distance
      logic rd_search;   // address the ring with the compare pointers
      logic step;        // bytes matched, move to next byte
      logic cand_end;    // candidate finished, keep best, next distance
      logic emit;        // load token into output register, advance
   } lzgm_cmd_type;

   typedef struct packed {
      logic go;          // accepted word triggers a token
      logic cand_any;    // at least one distance to search
      logic k_more;      // current candidate keeps matching
      logic cand_more;   // another candidate is worth searching
      logic out_free;    // output register can take a token
   } lzgm_sts_type;

endpackage

// ===== rtl/core/lzgm_ctrl.sv =====
// sequencer for the greedy lz77 match search
// depends on lzgm_pkg for command and status structs

module lzgm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  lzgm_pkg::lzgm_sts_type sts,
   output lzgm_pkg::lzgm_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_CAND,
      ST_READ,
      ST_CMP,
      ST_LIT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && sts.go) state_in = ST_SETUP;
         end
         ST_SETUP: begin
            state_in = sts.cand_any ? ST_CAND : ST_LIT;
         end
         ST_CAND: state_in = ST_READ;
         ST_READ: state_in = ST_CMP;
         ST_CMP: begin
            if (sts.k_more)         state_in = ST_READ;
            else if (sts.cand_more) state_in = ST_CAND;
            else                    state_in = ST_LIT;
         end
         ST_LIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd.ready     = (state_ff == ST_IDLE);
      cmd.setup     = (state_ff == ST_SETUP);
      cmd.cand_init = (state_ff == ST_CAND);
      cmd.rd_search = (state_ff == ST_READ);
      cmd.step      = (state_ff == ST_CMP) && sts.k_more;
      cmd.cand_end  = (state_ff == ST_CMP) && !sts.k_more;
      cmd.emit      = (state_ff == ST_EMIT) && sts.out_free;
   end

endmodule

// ===== rtl/core/lzgm_dp.sv =====
// datapath of the greedy lz77 compressor: byte ring, pointers, match search
// depends on lzgm_pkg; driven by lzgm_ctrl commands

module lzgm_dp #(
   parameter int WINDOW     = lzgm_pkg::WINDOW_DEF,
   parameter int LOOKAHEAD  = lzgm_pkg::LOOKAHEAD_DEF,
   parameter int RING_DEPTH = lzgm_pkg::RING_DEPTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic [lzgm_pkg::BYTE_W-1:0]        req_tdata,
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lzgm_pkg::RSP_W-1:0]         rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [lzgm_pkg::DIST_W-1:0]        csr_wdata,
   input  lzgm_pkg::lzgm_cmd_type             cmd,
   output lzgm_pkg::lzgm_sts_type             sts
);

   localparam int AW  = $clog2(RING_DEPTH);
   localparam int CAP = (WINDOW < RING_DEPTH - LOOKAHEAD) ? WINDOW : RING_DEPTH - LOOKAHEAD;
   localparam int DW  = lzgm_pkg::DIST_W;
   localparam int LW  = lzgm_pkg::LEN_W;
   localparam int BW  = lzgm_pkg::BYTE_W;
   localparam int RSP_W_L = lzgm_pkg::RSP_W;

   logic [BW-1:0] ring [RING_DEPTH];

   logic [DW-1:0] max_dist_ff;
   logic [LW-1:0] max_len_ff;
   logic [AW-1:0] wp_ff, cp_ff, pa_ff, pb_ff, pb_base_ff;
   logic [LW-1:0] pend_ff, limit_ff, k_ff, best_len_ff;
   logic [DW-1:0] hist_ff, d_ff, dmax_ff, best_dist_ff;
   logic          flush_ff;
   logic [BW-1:0] rd_a_ff, rd_b_ff;
   logic          rsp_valid_ff, rsp_last_ff;
   logic [RSP_W_L-1:0] rsp_data_ff;

   logic [LW-1:0] eff_len, pend_inc, kf, best_next;
   logic [DW-1:0] dmax_in, d_next, best_dist_next;
   logic [AW-1:0] addr_a, pb_base_dec;
   logic          accept, eq;
   logic [LW-1:0] adv;
   logic [AW:0]   cp_sum;
   logic [DW:0]   hist_sum;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
      return (p == '0) ? AW'(RING_DEPTH - 1) : p - 1'b1;
   endfunction

   // clamp of the length register
   always_comb begin
      eff_len = max_len_ff;
      if (eff_len < LW'(lzgm_pkg::SHORTEST_MATCH)) eff_len = LW'(lzgm_pkg::SHORTEST_MATCH);
      if (eff_len > LW'(LOOKAHEAD))               eff_len = LW'(LOOKAHEAD);
   end

   assign accept   = req_tvalid && cmd.ready;
   assign pend_inc = pend_ff + 1'b1;

   always_comb begin
      dmax_in = max_dist_ff;
      if (dmax_in > hist_ff)  dmax_in = hist_ff;
      if (dmax_in > DW'(CAP)) dmax_in = DW'(CAP);
   end

   assign eq          = (rd_a_ff == rd_b_ff);
   assign kf          = eq ? k_ff + 1'b1 : k_ff;
   assign d_next      = d_ff + 1'b1;
   assign pb_base_dec = wrap_dec(pb_base_ff);

   always_comb begin
      best_next      = best_len_ff;
      best_dist_next = best_dist_ff;
      if (kf >= LW'(lzgm_pkg::SHORTEST_MATCH) && kf > best_len_ff) begin
         best_next      = kf;
         best_dist_next = d_ff;
      end
   end

   always_comb begin
      sts.go        = (req_tuser == lzgm_pkg::CMD_PUSH) ? (pend_inc >= eff_len)
                                                         : (pend_ff != '0);
      sts.cand_any  = (dmax_in != '0);
      sts.k_more    = eq && (k_ff + 1'b1 < limit_ff);
      sts.cand_more = (d_next <= dmax_ff) && (best_next < limit_ff);
      sts.out_free  = !rsp_valid_ff || rsp_tready;
   end

   // ring port a follows the coding position unless the search owns it
   assign addr_a = cmd.rd_search ? pa_ff : cp_ff;

   always_ff @(posedge clock) begin
      if (accept && req_tuser == lzgm_pkg::CMD_PUSH) begin
         ring[wp_ff] <= req_tdata;
      end
      rd_a_ff <= ring[addr_a];
      rd_b_ff <= ring[pb_ff];
   end

   assign adv      = (best_len_ff != '0) ? best_len_ff : LW'(1);
   assign cp_sum   = {1'b0, cp_ff} + (AW+1)'(adv);
   assign hist_sum = {1'b0, hist_ff} + (DW+1)'(adv);

   // search registers need no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         flush_ff <= (req_tuser == lzgm_pkg::CMD_FLUSH);
         limit_ff <= (req_tuser == lzgm_pkg::CMD_FLUSH && eff_len > pend_ff) ? pend_ff
                                                                             : eff_len;
      end
      if (cmd.setup) begin
         dmax_ff      <= dmax_in;
         d_ff         <= DW'(1);
         pb_base_ff   <= wrap_dec(cp_ff);
      end
      if (cmd.cand_init) begin
         k_ff  <= '0;
         pa_ff <= cp_ff;
         pb_ff <= pb_base_ff;
      end
      if (cmd.step) begin
         k_ff  <= k_ff + 1'b1;
         pa_ff <= wrap_inc(pa_ff);
         pb_ff <= wrap_inc(pb_ff);
      end
      if (cmd.cand_end) begin
         best_dist_ff <= best_dist_next;
         d_ff         <= d_next;
         pb_base_ff   <= pb_base_dec;
      end
      if (cmd.emit) begin
         rsp_data_ff <= (best_len_ff != '0)
            ? RSP_W_L'({best_len_ff, best_dist_ff, {BW{1'b0}}, 1'b1})
            : RSP_W_L'({{LW{1'b0}}, {DW{1'b0}}, rd_a_ff, 1'b0});
         rsp_last_ff <= flush_ff && (pend_ff == adv);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_dist_ff  <= DW'(WINDOW);
         max_len_ff   <= LW'(LOOKAHEAD);
         wp_ff        <= '0;
         cp_ff        <= '0;
         pend_ff      <= '0;
         hist_ff      <= '0;
         best_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == lzgm_pkg::CSR_MAX_DISTANCE) max_dist_ff <= csr_wdata;
         if (csr_we && csr_index == lzgm_pkg::CSR_MAX_LENGTH)   max_len_ff  <= csr_wdata[LW-1:0];
         if (accept && req_tuser == lzgm_pkg::CMD_PUSH) begin
            wp_ff   <= wrap_inc(wp_ff);
            pend_ff <= pend_inc;
         end
         if (cmd.setup) best_len_ff <= '0;
         if (cmd.cand_end) best_len_ff <= best_next;
         if (cmd.emit) begin
            cp_ff   <= (cp_sum >= (AW+1)'(RING_DEPTH)) ? AW'(cp_sum - (AW+1)'(RING_DEPTH))
                                                       : cp_sum[AW-1:0];
            pend_ff <= pend_ff - adv;
            hist_ff <= (hist_sum > (DW+1)'(CAP)) ? DW'(CAP) : hist_sum[DW-1:0];
         end
         if (cmd.emit)          rsp_valid_ff <= 1'b1;
         else if (rsp_tready)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/core/lz77_greedy_match_compressor_core.sv =====
// top level of the greedy lz77 compressor: sequencer plus datapath
// depends on lzgm_pkg, lzgm_ctrl and lzgm_dp

// Greedy LZ77 compressor with a ring of RING_DEPTH bytes holding history and
// lookahead. Each request word either pushes one byte (tuser 0) or is one flush
// step (tuser 1). When max_length bytes are pending, or on a flush step with
// bytes pending, one token leaves on the rsp channel: the longest match of at
// least three bytes within max_distance, nearest distance winning ties, else a
// literal. A push that yields no token leaves the sequencer idle. A token first
// sets up the search, then for each candidate distance loads the compare
// pointers and, for every byte compared at that distance, reads the ring and
// then compares; last it fetches the literal and loads the output register. The
// ring's single pair of read ports reads one byte pair at a time, so a search
// costs more where candidates match partially and ends early once a candidate
// reaches the length limit. No clearing pass after reset; ring bytes are read
// only after they were written. The result sits in an output register, so a new
// request word is taken while a token waits; only the next token waits for it.

module lz77_greedy_match_compressor_core #(
   parameter int WINDOW     = lzgm_pkg::WINDOW_DEF,
   parameter int LOOKAHEAD  = lzgm_pkg::LOOKAHEAD_DEF,
   parameter int RING_DEPTH = lzgm_pkg::RING_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [lzgm_pkg::BYTE_W-1:0] req_tdata,   // data_byte
   input  logic                        req_tuser,   // cmd
   // token channel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [lzgm_pkg::RSP_W-1:0]  rsp_tdata,   // is_match, literal, distance, length, zero pad
   output logic                        rsp_tlast,   // last
   // register write port
   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [lzgm_pkg::DIST_W-1:0] csr_wdata
);

   lzgm_pkg::lzgm_cmd_type cmd;
   lzgm_pkg::lzgm_sts_type sts;

   // sequencer: one word at a time, walks candidates and bytes
   lzgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   // ring, pointers, best match and output register
   lzgm_dp #(
      .WINDOW     (WINDOW),
      .LOOKAHEAD  (LOOKAHEAD),
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // ready only while the sequencer idles
   assign req_tready = cmd.ready;

endmodule

// ===== rtl/core/lzgm_checker.sv =====
// port level checks on the greedy lz77 compressor, bound to the top level
// depends on lzgm_pkg for field widths

module lzgm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [lzgm_pkg::RSP_W-1:0]  rsp_tdata
);

   // a stalled token word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("token dropped or changed under stall");

   // literal tokens carry no distance or length
   a_lit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[24:9] == 16'd0 && rsp_tdata[33:25] == 9'd0)
      else $error("literal token with distance or length");

   // match tokens are at least three bytes at a real distance
   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[33:25] >= 9'd3 && rsp_tdata[24:9] != 16'd0
                                     && rsp_tdata[8:1] == 8'd0)
      else $error("malformed match token");

   // nothing offered straight after reset
   a_reset_quiet: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("token offered after reset");

endmodule

bind lz77_greedy_match_compressor_core lzgm_checker u_lzgm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/tb_lz77_greedy_match_compressor_core.sv =====
// self-checking testbench for the greedy lz77 match compressor core
// depends on lzgm_pkg and lz77_greedy_match_compressor_core; predicts tokens in-line

module tb_lz77_greedy_match_compressor_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_CAP    = 32768;   // min(window, ring depth - lookahead)
   localparam int STALL_LIMIT = 400000;  // cycles with no handshake before giving up

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
   } req_word_type;

   // laid out as the token word from bit 0 up, with last below it
   typedef struct packed {
      logic [8:0]  length;
      logic [15:0] distance;
      logic [7:0]  literal;
      logic        is_match;
      logic        last;
   } token_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lzgm_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [15:0] csr_wdata = '0;

   lz77_greedy_match_compressor_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state, kept as a shadow of the block
   logic [7:0]  shadow_ring [0:65535];
   logic [15:0] wr_ptr, code_ptr;
   int unsigned n_pending, n_history;
   int unsigned reg_max_dist, reg_max_len;

   req_word_type req_queue[$];
   token_type    token_queue[$];
   int        mismatches = 0;
   int        idle_cycles = 0;
   bit        pace_tx = 1'b0;
   bit        tx_taken = 1'b0;

   // most gaps short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // greedy search at the coding position, pushes the token it produces
   task automatic code_token(input int unsigned lim, input bit flushing);
      int unsigned dmax, best_len, best_dist, k, adv;
      token_type t;
      dmax = reg_max_dist;
      if (dmax > n_history) dmax = n_history;
      if (dmax > HIST_CAP) dmax = HIST_CAP;
      best_len = 0;
      best_dist = 0;
      for (int unsigned d = 1; d <= dmax && best_len < lim; d++) begin
         k = 0;
         while (k < lim && shadow_ring[16'(code_ptr + k)] == shadow_ring[16'(code_ptr + k - d)])
            k++;
         if (k >= lzgm_pkg::SHORTEST_MATCH && k > best_len) begin
            best_len = k;
            best_dist = d;
         end
      end
      t = '0;
      if (best_len > 0) begin
         t.is_match = 1'b1;
         t.distance = 16'(best_dist);
         t.length = 9'(best_len);
         adv = best_len;
      end else begin
         t.literal = shadow_ring[code_ptr];
         adv = 1;
      end
      code_ptr = 16'(code_ptr + adv);
      n_pending -= adv;
      n_history += adv;
      if (n_history > HIST_CAP) n_history = HIST_CAP;
      t.last = flushing && n_pending == 0;
      token_queue.push_back(t);
   endtask

   // apply one accepted request word to the shadow state
   task automatic predict_word(input req_word_type w);
      int unsigned lim;
      lim = reg_max_len;
      if (lim < lzgm_pkg::SHORTEST_MATCH) lim = lzgm_pkg::SHORTEST_MATCH;
      if (lim > lzgm_pkg::LOOKAHEAD_DEF) lim = lzgm_pkg::LOOKAHEAD_DEF;
      if (w.cmd == lzgm_pkg::CMD_PUSH) begin
         shadow_ring[wr_ptr] = w.data;
         wr_ptr = wr_ptr + 16'd1;
         n_pending++;
         if (n_pending >= lim) code_token(lim, 1'b0);
      end else if (n_pending != 0) begin
         if (lim > n_pending) lim = n_pending;
         code_token(lim, 1'b1);
      end
   endtask

   // driver: request words from the queue, random gaps between them
   int tx_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !tx_taken) begin
            // hold the word until it is taken
         end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 1'b0;
         end else if (req_queue.size() != 0 && pace_tx) begin
            req_tvalid <= 1'b1;
            req_tuser <= req_queue[0].cmd;
            req_tdata <= req_queue[0].data;
            void'(req_queue.pop_front());
            tx_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // acceptance of request words feeds the predictor
   always @(posedge clock) begin
      tx_taken <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready)
         predict_word('{cmd: req_tuser, data: req_tdata});
   end

   // receiver stalls at random, with long stretches of steady ready
   int rx_gap = 0;
   always @(negedge clock) begin
      if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 7) == 0) rx_gap <= gap_len();
      end
   end

   // monitor: compare each token word with the oldest expectation
   always @(posedge clock) begin
      token_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[33:0], rsp_tlast};
         if (token_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected token %h", got);
         end else begin
            want = token_queue.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"token mismatch: match %0d/%0d lit %h/%h dist %0d/%0d",
                            " len %0d/%0d last %0d/%0d"},
                     want.is_match, got.is_match, want.literal, got.literal,
                     want.distance, got.distance, want.length, got.length,
                     want.last, got.last);
            end
         end
      end
   end

   // watchdog on handshake-free cycles
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic push_byte(input logic [7:0] b);
      req_queue.push_back('{cmd: lzgm_pkg::CMD_PUSH, data: b});
   endtask

   task automatic flush_all(input int n);
      repeat (n) req_queue.push_back('{cmd: lzgm_pkg::CMD_FLUSH, data: 8'($urandom)});
   endtask

   // wait for the stimulus to drain and every token to return, then settle
   task automatic drain();
      pace_tx = 1'b1;
      while (req_queue.size() != 0 || req_tvalid || token_queue.size() != 0)
         @(posedge clock);
      // a push with no token may still be in flight
      repeat (20) @(posedge clock);
      pace_tx = 1'b0;
   endtask

   task automatic write_reg(input logic idx, input logic [15:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == lzgm_pkg::CSR_MAX_DISTANCE) reg_max_dist = val;
      else reg_max_len = val[8:0];
   endtask

   // one random phase: repetitive stream with random content, then flushes
   task automatic random_phase(input int n);
      logic [7:0] alphabet;
      alphabet = 8'($urandom_range(1, 7));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) flush_all(1);
         else if ($urandom_range(0, 9) == 0) push_byte(8'($urandom));
         else push_byte(8'($urandom_range(0, alphabet)));
      end
      flush_all(n);
   endtask

   initial begin
      wr_ptr = '0;
      code_ptr = '0;
      n_pending = 0;
      n_history = 0;
      reg_max_dist = 32768;
      reg_max_len = 258;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // short tokens and small window first so the search stays quick
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd3);
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd0);
      flush_all(1);                    // flush with nothing pending
      push_byte(8'h00); push_byte(8'hFF); push_byte(8'hA5);
      push_byte(8'h00); push_byte(8'hFF);
      flush_all(4);                    // distance zero forces literals
      drain();

      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd8);
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd8);
      for (int i = 0; i < 12; i++) push_byte(8'h5A);   // overlapping run
      push_byte(8'h01); push_byte(8'h02); push_byte(8'h01); push_byte(8'h02);
      req_queue.push_back('{cmd: lzgm_pkg::CMD_FLUSH, data: 8'hFF});  // byte ignored on flush
      flush_all(8);                    // short pending tail
      drain();

      // out-of-range length register, clamped both ways
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd0);
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd16);
      random_phase(5);
      drain();
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'h01FF);
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd1);
      random_phase(10);
      drain();

      // lowered length while bytes are pending
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd20);
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd40);
      for (int i = 0; i < 12; i++) push_byte(8'($urandom_range(0, 2)));
      drain();
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd4);
      random_phase(5);
      drain();

      // full range registers on a short stream, history stays small
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd258);
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'hFFFF);
      random_phase(6);
      drain();
      write_reg(lzgm_pkg::CSR_MAX_DISTANCE, 16'd32768);
      write_reg(lzgm_pkg::CSR_MAX_LENGTH, 16'd6);
      random_phase(6);
      drain();

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
